/* rtl/gnl_pkg.sv */
// Shared types, codes and helpers for the grouped name lookup block.
// Used by gnl_ctrl, gnl_datapath and grouped_name_lookup; depends on nothing.
`default_nettype none

package gnl_pkg;

   localparam int MAX_GROUPS_DEF     = 16;
   localparam int MAX_ENTRIES_DEF    = 16;
   localparam int MAX_NAME_BYTES_DEF = 8;

   localparam int NAME_W    = 64;
   localparam int LEN_W     = 4;
   localparam int SECTION_W = 5;
   localparam int OFFSET_W  = 16;
   localparam int INDEX_W   = 4;
   localparam int COUNT_W   = 4;
   localparam int STATUS_W  = 3;

   // request codes
   localparam logic [1:0] CMD_CLEAR     = 2'd0;
   localparam logic [1:0] CMD_ADD_GROUP = 2'd1;
   localparam logic [1:0] CMD_ADD_ENTRY = 2'd2;
   localparam logic [1:0] CMD_QUERY     = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_GROUP = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_G_READ,
      S_G_CMP,
      S_E_READ,
      S_E_CMP,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic g_cmp;
      logic e_cmp;
      logic finish;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic g_open;
      logic g_hit;
      logic e_open;
      logic e_hit;
      logic rsp_free;
   } dp_stat_type;

   // Keeps the first min(len, max_bytes) bytes, first byte in the top lane.
   function automatic logic [NAME_W-1:0] prefix_mask(input logic [LEN_W-1:0] len,
                                                     input int max_bytes);
      logic [NAME_W-1:0] m;
      int b;
      m = '0;
      for (b = 0; b < 8; b++) begin
         if (b < int'(len) && b < max_bytes) begin
            m[NAME_W-1-8*b -: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* rtl/gnl_ctrl.sv */
// Sequencing state machine for the grouped name lookup.
// Depends on gnl_pkg; drives gnl_datapath through command and status structs.
`default_nettype none

module gnl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_cmd,
   output logic                     req_ready,
   input  wire gnl_pkg::dp_stat_type stat_i,
   output gnl_pkg::ctl_cmd_type     cmd_o
);

   gnl_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gnl_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == gnl_pkg::CMD_QUERY) ? gnl_pkg::S_G_READ
                                                          : gnl_pkg::S_DONE;
            end
         end
         gnl_pkg::S_G_READ: begin
            state_in = stat_i.g_open ? gnl_pkg::S_G_CMP : gnl_pkg::S_DONE;
         end
         gnl_pkg::S_G_CMP: begin
            state_in = stat_i.g_hit ? gnl_pkg::S_E_READ : gnl_pkg::S_G_READ;
         end
         gnl_pkg::S_E_READ: begin
            state_in = stat_i.e_open ? gnl_pkg::S_E_CMP : gnl_pkg::S_DONE;
         end
         gnl_pkg::S_E_CMP: begin
            state_in = stat_i.e_hit ? gnl_pkg::S_DONE : gnl_pkg::S_E_READ;
         end
         gnl_pkg::S_DONE: begin
            if (stat_i.rsp_free) begin
               state_in = gnl_pkg::S_IDLE;
            end
         end
         default: state_in = gnl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == gnl_pkg::S_IDLE);
      cmd_o.accept  = (state_ff == gnl_pkg::S_IDLE) && req_valid;
      cmd_o.g_cmp   = (state_ff == gnl_pkg::S_G_CMP);
      cmd_o.e_cmp   = (state_ff == gnl_pkg::S_E_CMP);
      cmd_o.finish  = (state_ff == gnl_pkg::S_DONE) && stat_i.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gnl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/gnl_datapath.sv */
// Table memories, search bounds, comparators and response register.
// Depends on gnl_pkg; steered by gnl_ctrl.
`default_nettype none

module gnl_datapath #(
   parameter int MAX_GROUPS     = gnl_pkg::MAX_GROUPS_DEF,
   parameter int MAX_ENTRIES    = gnl_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_NAME_BYTES = gnl_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gnl_pkg::ctl_cmd_type              cmd_i,
   output gnl_pkg::dp_stat_type                   stat_o,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [gnl_pkg::LEN_W-1:0]         req_name_length,
   input  wire logic [gnl_pkg::NAME_W-1:0]        req_name_word,
   input  wire logic [gnl_pkg::SECTION_W-1:0]     req_entry_section,
   input  wire logic [gnl_pkg::OFFSET_W-1:0]      req_entry_offset,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gnl_pkg::STATUS_W-1:0]           rsp_status,
   output logic [gnl_pkg::SECTION_W-1:0]          rsp_hit_section,
   output logic [gnl_pkg::OFFSET_W-1:0]           rsp_hit_offset,
   output logic [gnl_pkg::INDEX_W-1:0]            rsp_hit_group,
   output logic [gnl_pkg::INDEX_W-1:0]            rsp_hit_entry,
   output logic [gnl_pkg::COUNT_W-1:0]            rsp_compare_count
);

   localparam int GCW   = $clog2(MAX_GROUPS + 1);
   localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int ECW   = $clog2(MAX_ENTRIES + 1);
   localparam int EIW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SLOTS = MAX_GROUPS * MAX_ENTRIES;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW    = gnl_pkg::NAME_W;

   // table memories
   logic [gnl_pkg::LEN_W-1:0]     glen_mem   [MAX_GROUPS];
   logic [ECW-1:0]                gcount_mem [MAX_GROUPS];
   logic [NW-1:0]                 ename_mem  [SLOTS];
   logic [gnl_pkg::SECTION_W-1:0] esec_mem   [SLOTS];
   logic [gnl_pkg::OFFSET_W-1:0]  eoff_mem   [SLOTS];

   logic [gnl_pkg::LEN_W-1:0]     glen_rd_ff;
   logic [ECW-1:0]                gcount_rd_ff;
   logic [NW-1:0]                 ename_rd_ff;
   logic [gnl_pkg::SECTION_W-1:0] esec_rd_ff;
   logic [gnl_pkg::OFFSET_W-1:0]  eoff_rd_ff;

   logic [GCW-1:0]             group_total_ff, group_total_in;
   logic [ECW-1:0]             last_count_ff, last_count_in;
   logic [gnl_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [NW-1:0]              mask_ff, mask_in;
   logic [NW-1:0]              key_ff, key_in;
   logic [GCW-1:0]             glo_ff, glo_in, ghx_ff, ghx_in;
   logic [ECW-1:0]             elo_ff, elo_in, ehx_ff, ehx_in;
   logic [SW-1:0]              base_ff, base_in;
   logic [gnl_pkg::COUNT_W-1:0] cnt_ff, cnt_in;

   logic [gnl_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [gnl_pkg::SECTION_W-1:0] res_section_ff, res_section_in;
   logic [gnl_pkg::OFFSET_W-1:0]  res_offset_ff, res_offset_in;
   logic [gnl_pkg::INDEX_W-1:0]   res_group_ff, res_group_in;
   logic [gnl_pkg::INDEX_W-1:0]   res_entry_ff, res_entry_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gnl_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [gnl_pkg::SECTION_W-1:0] rsp_section_ff, rsp_section_in;
   logic [gnl_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [gnl_pkg::INDEX_W-1:0]   rsp_group_ff, rsp_group_in;
   logic [gnl_pkg::INDEX_W-1:0]   rsp_entry_ff, rsp_entry_in;
   logic [gnl_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // probe midpoints: floor((lo + hi) / 2) with hi = hx - 1
   logic [GCW:0]   gsum;
   logic [GIW-1:0] gmid;
   logic [ECW:0]   esum;
   logic [EIW-1:0] emid;
   logic [SW-1:0]  erd_addr;
   logic [GIW-1:0] last_g;
   logic [NW-1:0]  probe_name;
   logic           g_hit, e_hit, e_less;

   // write ports
   logic                          gl_we;
   logic [GIW-1:0]                gl_wa;
   logic                          gc_we;
   logic [GIW-1:0]                gc_wa;
   logic [ECW-1:0]                gc_wd;
   logic                          ent_we;
   logic [SW-1:0]                 ent_wa;

   assign gsum       = (GCW+1)'(glo_ff) + (GCW+1)'(ghx_ff) - (GCW+1)'(1);
   assign gmid       = gsum[GIW:1];
   assign esum       = (ECW+1)'(elo_ff) + (ECW+1)'(ehx_ff) - (ECW+1)'(1);
   assign emid       = esum[EIW:1];
   assign erd_addr   = base_ff + SW'(emid);
   assign last_g     = GIW'(group_total_ff - GCW'(1));
   assign gl_wa      = group_total_ff[GIW-1:0];
   assign probe_name = ename_rd_ff & mask_ff;
   assign g_hit      = (glen_rd_ff == len_ff);
   assign e_hit      = (probe_name == key_ff);
   assign e_less     = (key_ff < probe_name);

   always_comb begin
      stat_o.g_open   = (glo_ff < ghx_ff);
      stat_o.g_hit    = g_hit;
      stat_o.e_open   = (elo_ff < ehx_ff);
      stat_o.e_hit    = e_hit;
      stat_o.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      group_total_in = group_total_ff;
      last_count_in  = last_count_ff;
      len_in         = len_ff;
      mask_in        = mask_ff;
      key_in         = key_ff;
      glo_in         = glo_ff;
      ghx_in         = ghx_ff;
      elo_in         = elo_ff;
      ehx_in         = ehx_ff;
      base_in        = base_ff;
      cnt_in         = cnt_ff;
      res_status_in  = res_status_ff;
      res_section_in = res_section_ff;
      res_offset_in  = res_offset_ff;
      res_group_in   = res_group_ff;
      res_entry_in   = res_entry_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_section_in = rsp_section_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_group_in   = rsp_group_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_count_in   = rsp_count_ff;
      gl_we          = 1'b0;
      gc_we          = 1'b0;
      gc_wa          = gl_wa;
      gc_wd          = '0;
      ent_we         = 1'b0;
      ent_wa         = SW'(last_g * MAX_ENTRIES) + SW'(last_count_ff[EIW-1:0]);

      if (cmd_i.accept) begin
         cnt_in         = '0;
         res_section_in = '0;
         res_offset_in  = '0;
         res_group_in   = '0;
         res_entry_in   = '0;
         len_in         = req_name_length;
         mask_in        = gnl_pkg::prefix_mask(req_name_length, MAX_NAME_BYTES);
         key_in         = req_name_word &
                          gnl_pkg::prefix_mask(req_name_length, MAX_NAME_BYTES);
         glo_in         = '0;
         ghx_in         = group_total_ff;
         unique case (req_cmd)
            gnl_pkg::CMD_CLEAR: begin
               group_total_in = '0;
               res_status_in  = gnl_pkg::STAT_ACCEPTED;
            end
            gnl_pkg::CMD_ADD_GROUP: begin
               if (group_total_ff == GCW'(MAX_GROUPS)) begin
                  res_status_in = gnl_pkg::STAT_FULL;
               end else begin
                  gl_we          = 1'b1;
                  gc_we          = 1'b1;
                  group_total_in = group_total_ff + GCW'(1);
                  last_count_in  = '0;
                  res_status_in  = gnl_pkg::STAT_ACCEPTED;
               end
            end
            gnl_pkg::CMD_ADD_ENTRY: begin
               if (group_total_ff == '0 || last_count_ff == ECW'(MAX_ENTRIES)) begin
                  res_status_in = gnl_pkg::STAT_FULL;
               end else begin
                  ent_we        = 1'b1;
                  gc_we         = 1'b1;
                  gc_wa         = last_g;
                  gc_wd         = last_count_ff + ECW'(1);
                  last_count_in = last_count_ff + ECW'(1);
                  res_status_in = gnl_pkg::STAT_ACCEPTED;
               end
            end
            gnl_pkg::CMD_QUERY: begin
               res_status_in = gnl_pkg::STAT_NO_GROUP;
            end
            default: res_status_in = gnl_pkg::STAT_NO_GROUP;
         endcase
      end

      if (cmd_i.g_cmp) begin
         if (cnt_ff != '1) begin
            cnt_in = cnt_ff + gnl_pkg::COUNT_W'(1);
         end
         if (g_hit) begin
            base_in       = SW'(gmid * MAX_ENTRIES);
            elo_in        = '0;
            ehx_in        = gcount_rd_ff;
            res_status_in = gnl_pkg::STAT_ABSENT;
            res_group_in  = gnl_pkg::INDEX_W'(gmid);
         end else if (len_ff < glen_rd_ff) begin
            ghx_in = GCW'(gmid);
         end else begin
            glo_in = GCW'(gmid) + GCW'(1);
         end
      end

      if (cmd_i.e_cmp) begin
         if (cnt_ff != '1) begin
            cnt_in = cnt_ff + gnl_pkg::COUNT_W'(1);
         end
         if (e_hit) begin
            res_status_in  = gnl_pkg::STAT_FOUND;
            res_section_in = esec_rd_ff;
            res_offset_in  = eoff_rd_ff;
            res_entry_in   = gnl_pkg::INDEX_W'(emid);
         end else if (e_less) begin
            ehx_in = ECW'(emid);
         end else begin
            elo_in = ECW'(emid) + ECW'(1);
         end
      end

      // output register: drains on transfer, refills when a result is done
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd_i.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_section_in = res_section_ff;
         rsp_offset_in  = res_offset_ff;
         rsp_group_in   = res_group_ff;
         rsp_entry_in   = res_entry_ff;
         rsp_count_in   = cnt_ff;
      end
   end

   // group tables, read data registered
   always_ff @(posedge clock) begin
      if (gl_we) begin
         glen_mem[gl_wa] <= req_name_length;
      end
      if (gc_we) begin
         gcount_mem[gc_wa] <= gc_wd;
      end
      glen_rd_ff   <= glen_mem[gmid];
      gcount_rd_ff <= gcount_mem[gmid];
   end

   // entry tables, read data registered
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ename_mem[ent_wa] <= req_name_word;
         esec_mem[ent_wa]  <= req_entry_section;
         eoff_mem[ent_wa]  <= req_entry_offset;
      end
      ename_rd_ff <= ename_mem[erd_addr];
      esec_rd_ff  <= esec_mem[erd_addr];
      eoff_rd_ff  <= eoff_mem[erd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         group_total_ff <= group_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_count_ff  <= last_count_in;
      len_ff         <= len_in;
      mask_ff        <= mask_in;
      key_ff         <= key_in;
      glo_ff         <= glo_in;
      ghx_ff         <= ghx_in;
      elo_ff         <= elo_in;
      ehx_ff         <= ehx_in;
      base_ff        <= base_in;
      cnt_ff         <= cnt_in;
      res_status_ff  <= res_status_in;
      res_section_ff <= res_section_in;
      res_offset_ff  <= res_offset_in;
      res_group_ff   <= res_group_in;
      res_entry_ff   <= res_entry_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_section_ff <= rsp_section_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_group_ff   <= rsp_group_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_hit_section   = rsp_section_ff;
   assign rsp_hit_offset    = rsp_offset_ff;
   assign rsp_hit_group     = rsp_group_ff;
   assign rsp_hit_entry     = rsp_entry_ff;
   assign rsp_compare_count = rsp_count_ff;

endmodule

`default_nettype wire

/* rtl/grouped_name_lookup.sv */
// Loads and clears go straight to the done state; a query searches the groups by length,
// then the entries of the hit group by masked name, and ends when a search level runs out
// or an entry hits (at most 5 + 5 probes with 16 groups of 16 entries).
// Each probe is the registered read of a table memory, then the compare.
// One item at a time; the next request is taken once the last result is in the
// output register. Reset clears the group count and response valid; tables are not cleared.
`default_nettype none

module grouped_name_lookup #(
   parameter int MAX_GROUPS     = gnl_pkg::MAX_GROUPS_DEF,
   parameter int MAX_ENTRIES    = gnl_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_NAME_BYTES = gnl_pkg::MAX_NAME_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [gnl_pkg::LEN_W-1:0]     req_name_length,
   input  wire logic [gnl_pkg::NAME_W-1:0]    req_name_word,
   input  wire logic [gnl_pkg::SECTION_W-1:0] req_entry_section,
   input  wire logic [gnl_pkg::OFFSET_W-1:0]  req_entry_offset,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gnl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [gnl_pkg::SECTION_W-1:0]      rsp_hit_section,
   output logic [gnl_pkg::OFFSET_W-1:0]       rsp_hit_offset,
   output logic [gnl_pkg::INDEX_W-1:0]        rsp_hit_group,
   output logic [gnl_pkg::INDEX_W-1:0]        rsp_hit_entry,
   output logic [gnl_pkg::COUNT_W-1:0]        rsp_compare_count
);

   gnl_pkg::ctl_cmd_type ctl_cmd;
   gnl_pkg::dp_stat_type dp_stat;

   gnl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .stat_i    (dp_stat),
      .cmd_o     (ctl_cmd)
   );

   gnl_datapath #(
      .MAX_GROUPS     (MAX_GROUPS),
      .MAX_ENTRIES    (MAX_ENTRIES),
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (ctl_cmd),
      .stat_o            (dp_stat),
      .req_cmd           (req_cmd),
      .req_name_length   (req_name_length),
      .req_name_word     (req_name_word),
      .req_entry_section (req_entry_section),
      .req_entry_offset  (req_entry_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_hit_section   (rsp_hit_section),
      .rsp_hit_offset    (rsp_hit_offset),
      .rsp_hit_group     (rsp_hit_group),
      .rsp_hit_entry     (rsp_hit_entry),
      .rsp_compare_count (rsp_compare_count)
   );

endmodule

`default_nettype wire

/* tb/sv/gnl_checker.sv */
// Checker for grouped_name_lookup: keeps its own copy of the symbol table,
// predicts the answer to every request transfer and compares response transfers.
// Depends on gnl_pkg for widths and codes.
module gnl_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [gnl_pkg::LEN_W-1:0]     req_name_length,
   input  wire logic [gnl_pkg::NAME_W-1:0]    req_name_word,
   input  wire logic [gnl_pkg::SECTION_W-1:0] req_entry_section,
   input  wire logic [gnl_pkg::OFFSET_W-1:0]  req_entry_offset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [gnl_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic [gnl_pkg::SECTION_W-1:0] rsp_hit_section,
   input  wire logic [gnl_pkg::OFFSET_W-1:0]  rsp_hit_offset,
   input  wire logic [gnl_pkg::INDEX_W-1:0]   rsp_hit_group,
   input  wire logic [gnl_pkg::INDEX_W-1:0]   rsp_hit_entry,
   input  wire logic [gnl_pkg::COUNT_W-1:0]   rsp_compare_count,
   output int                                 failures,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gnl_pkg::*;

   localparam int GROUPS       = MAX_GROUPS_DEF;
   localparam int ENTRIES      = MAX_ENTRIES_DEF;
   localparam int NAME_BYTES   = MAX_NAME_BYTES_DEF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SECTION_W-1:0] section;
      logic [OFFSET_W-1:0]  offset;
      logic [INDEX_W-1:0]   group;
      logic [INDEX_W-1:0]   entry;
      logic [COUNT_W-1:0]   compares;
   } answer_type;

   int unsigned          loaded_groups;
   logic [LEN_W-1:0]     len_of_group [GROUPS];
   int unsigned          fill_of_group [GROUPS];
   logic [NAME_W-1:0]    name_at [GROUPS*ENTRIES];
   logic [SECTION_W-1:0] section_at [GROUPS*ENTRIES];
   logic [OFFSET_W-1:0]  offset_at [GROUPS*ENTRIES];
   answer_type           expected_answers [$];
   answer_type           got, want;
   int                   fail_count = 0;

   assign failures = fail_count;

   // bytes past the compared length drop out; lengths above the name width clamp
   function automatic logic [NAME_W-1:0] compare_mask(input logic [LEN_W-1:0] len);
      int nbytes;
      nbytes = (int'(len) > NAME_BYTES) ? NAME_BYTES : int'(len);
      if (nbytes == 0) return '0;
      return {NAME_W{1'b1}} << (NAME_W - 8*nbytes);
   endfunction

   function automatic answer_type lookup_and_update(input logic [1:0]           cmd,
                                                    input logic [LEN_W-1:0]     len,
                                                    input logic [NAME_W-1:0]    word,
                                                    input logic [SECTION_W-1:0] sec,
                                                    input logic [OFFSET_W-1:0]  off);
      answer_type a;
      int lo, hi, mid, grp, ent, probes, slot;
      logic [NAME_W-1:0] mask, key, probe_name;
      a = '0;
      a.status = STAT_ACCEPTED;
      case (cmd)
         CMD_CLEAR: loaded_groups = 0;
         CMD_ADD_GROUP: begin
            if (loaded_groups >= GROUPS) begin
               a.status = STAT_FULL;
            end else begin
               len_of_group[loaded_groups] = len;
               fill_of_group[loaded_groups] = 0;
               loaded_groups++;
            end
         end
         CMD_ADD_ENTRY: begin
            if (loaded_groups == 0) begin
               a.status = STAT_FULL;
            end else begin
               grp = int'(loaded_groups) - 1;
               if (fill_of_group[grp] >= ENTRIES) begin
                  a.status = STAT_FULL;
               end else begin
                  slot = grp*ENTRIES + int'(fill_of_group[grp]);
                  name_at[slot] = word;
                  section_at[slot] = sec;
                  offset_at[slot] = off;
                  fill_of_group[grp]++;
               end
            end
         end
         CMD_QUERY: begin
            probes = 0;
            grp = -1;
            lo = 0;
            hi = int'(loaded_groups) - 1;
            while (lo <= hi && grp < 0) begin
               mid = (lo + hi) / 2;
               probes++;
               if (len_of_group[mid] == len) grp = mid;
               else if (len < len_of_group[mid]) hi = mid - 1;
               else lo = mid + 1;
            end
            if (grp < 0) begin
               a.status = STAT_NO_GROUP;
            end else begin
               mask = compare_mask(len);
               key = word & mask;
               ent = -1;
               lo = 0;
               hi = int'(fill_of_group[grp]) - 1;
               while (lo <= hi && ent < 0) begin
                  mid = (lo + hi) / 2;
                  probes++;
                  probe_name = name_at[grp*ENTRIES + mid] & mask;
                  if (probe_name == key) ent = mid;
                  else if (key < probe_name) hi = mid - 1;
                  else lo = mid + 1;
               end
               a.group = grp[INDEX_W-1:0];
               if (ent < 0) begin
                  a.status = STAT_ABSENT;
               end else begin
                  slot = grp*ENTRIES + ent;
                  a.status = STAT_FOUND;
                  a.section = section_at[slot];
                  a.offset = offset_at[slot];
                  a.entry = ent[INDEX_W-1:0];
               end
            end
            a.compares = (probes > 15) ? {COUNT_W{1'b1}} : probes[COUNT_W-1:0];
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic string describe(input answer_type a);
      return $sformatf("st=%0d sec=%0d off=%h grp=%0d ent=%0d cmp=%0d",
                       a.status, a.section, a.offset, a.group, a.entry, a.compares);
   endfunction

   task automatic note_failure(input string what, input answer_type exp_a,
                               input answer_type act_a);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t %s: expected %s, got %s", $time, what, describe(exp_a),
                  describe(act_a));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded_groups = 0;
         expected_answers.delete();
         pending <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_answers.push_back(lookup_and_update(req_cmd, req_name_length,
               req_name_word, req_entry_section, req_entry_offset));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_hit_section, rsp_hit_offset, rsp_hit_group,
                   rsp_hit_entry, rsp_compare_count};
            if (expected_answers.size() == 0) begin
               note_failure("response with nothing expected", '0, got);
            end else begin
               want = expected_answers.pop_front();
               if (want !== got) note_failure("response mismatch", want, got);
            end
         end
         pending <= expected_answers.size();
      end
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the grouped_name_lookup testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on gnl_pkg, gnl_checker and the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gnl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_ITEMS = 1750;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_cmd;
   logic [LEN_W-1:0]     req_name_length;
   logic [NAME_W-1:0]    req_name_word;
   logic [SECTION_W-1:0] req_entry_section;
   logic [OFFSET_W-1:0]  req_entry_offset;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SECTION_W-1:0] rsp_hit_section;
   logic [OFFSET_W-1:0]  rsp_hit_offset;
   logic [INDEX_W-1:0]   rsp_hit_group;
   logic [INDEX_W-1:0]   rsp_hit_entry;
   logic [COUNT_W-1:0]   rsp_compare_count;
   int                   failures;
   int                   pending;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int items_sent = 0;

   // what the stimulus believes is loaded, used to aim queries at real names
   int                shadow_groups;
   logic [LEN_W-1:0]  shadow_len [16];
   int                shadow_fill [16];
   logic [NAME_W-1:0] shadow_name [16][16];

   grouped_name_lookup u_dut (.*);
   gnl_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

   always @(posedge clock) rsp_ready <= (int'($urandom_range(99)) >= rx_idle_pct);

   function automatic logic [NAME_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [1:0] rand_cmd();
      return 2'($urandom);
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      return LEN_W'($urandom);
   endfunction

   function automatic logic [SECTION_W-1:0] rand_sec();
      return SECTION_W'($urandom);
   endfunction

   function automatic logic [OFFSET_W-1:0] rand_off();
      return OFFSET_W'($urandom);
   endfunction

   // significant bytes of a name of this length
   function automatic logic [NAME_W-1:0] name_span(input logic [LEN_W-1:0] len);
      int n;
      n = (len > 8) ? 8 : int'(len);
      return (n == 0) ? '0 : ({NAME_W{1'b1}} << (NAME_W - 8*n));
   endfunction

   task automatic send_req(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
                           input logic [NAME_W-1:0] word, input logic [SECTION_W-1:0] sec,
                           input logic [OFFSET_W-1:0] off);
      while (int'($urandom_range(99)) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_name_length <= len;
      req_name_word <= word;
      req_entry_section <= sec;
      req_entry_offset <= off;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic build_table(input int group_goal, input int max_fill, input bit in_order,
                              input bit overflow);
      int lo_len, hi_len, need, l, g, e, j, fill;
      logic [NAME_W-1:0] span, tmp, stray;
      send_req(CMD_CLEAR, rand_len(), rand_word(), rand_sec(), rand_off());
      shadow_groups = 0;
      if (in_order) begin
         // sample distinct lengths in ascending order
         if (group_goal > 8 || $urandom_range(3) == 0) begin
            lo_len = 0;
            hi_len = 15;
         end else begin
            lo_len = 1;
            hi_len = 8;
         end
         need = group_goal;
         for (l = lo_len; l <= hi_len && need > 0; l++) begin
            if (int'($urandom_range(hi_len - l)) < need) begin
               shadow_len[shadow_groups] = l[LEN_W-1:0];
               shadow_groups++;
               need--;
            end
         end
      end else begin
         shadow_groups = group_goal;
         for (g = 0; g < group_goal; g++) shadow_len[g] = LEN_W'($urandom_range(15));
      end
      for (g = 0; g < shadow_groups; g++) begin
         span = name_span(shadow_len[g]);
         fill = $urandom_range(max_fill);
         shadow_fill[g] = fill;
         for (e = 0; e < fill; e++) shadow_name[g][e] = rand_word() & span;
         if (in_order) begin
            for (e = 1; e < fill; e++) begin
               tmp = shadow_name[g][e];
               for (j = e; j > 0 && shadow_name[g][j-1] > tmp; j--)
                  shadow_name[g][j] = shadow_name[g][j-1];
               shadow_name[g][j] = tmp;
            end
         end
         send_req(CMD_ADD_GROUP, shadow_len[g], rand_word(), rand_sec(), rand_off());
         for (e = 0; e < fill; e++) begin
            stray = ($urandom_range(7) == 0) ? (rand_word() & ~span) : '0;
            send_req(CMD_ADD_ENTRY, rand_len(), shadow_name[g][e] | stray, rand_sec(),
                     rand_off());
         end
      end
      if (overflow) begin
         send_req(CMD_ADD_ENTRY, rand_len(), rand_word(), rand_sec(), rand_off());
         send_req(CMD_ADD_GROUP, rand_len(), rand_word(), rand_sec(), rand_off());
      end
   endtask

   task automatic run_queries(input int count);
      int q, roll, g, e;
      logic [LEN_W-1:0] len;
      logic [NAME_W-1:0] word, span, step;
      for (q = 0; q < count; q++) begin
         roll = $urandom_range(99);
         len = LEN_W'($urandom_range(15));
         word = rand_word();
         if (shadow_groups > 0 && roll < 75) begin
            g = $urandom_range(shadow_groups - 1);
            len = shadow_len[g];
            span = name_span(len);
            step = (span == '0) ? '0 : (span & ~(span << 1));
            if (shadow_fill[g] > 0 && roll < 60) begin
               e = $urandom_range(shadow_fill[g] - 1);
               word = shadow_name[g][e] | (($urandom_range(3) == 0) ? (word & ~span) : '0);
            end else if (shadow_fill[g] > 0 && roll < 68) begin
               // just beside a loaded name
               e = $urandom_range(shadow_fill[g] - 1);
               word = $urandom_range(1) ? shadow_name[g][e] + step : shadow_name[g][e] - step;
            end else begin
               word = word & span;
            end
         end
         if (roll >= 96)
            send_req(rand_cmd(), len, word, rand_sec(), rand_off());
         else
            send_req(CMD_QUERY, len, word, rand_sec(), rand_off());
      end
   endtask

   initial begin
      int phase, phase_end, group_goal;
      bit first_build;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_CLEAR;
      req_name_length <= '0;
      req_name_word <= '0;
      req_entry_section <= '0;
      req_entry_offset <= '0;
      tx_idle_pct = 7;
      rx_idle_pct = 46;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, zero length, byte extremes, long lengths, clear
      send_req(CMD_CLEAR, 4'd0, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_ENTRY, 4'd0, '1, 5'd31, 16'hFFFF);
      send_req(CMD_QUERY, 4'd3, 64'h4142_4300_0000_0000, 5'd0, 16'd0);
      send_req(CMD_ADD_GROUP, 4'd0, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_ENTRY, 4'd0, '1, 5'd31, 16'hFFFF);
      send_req(CMD_QUERY, 4'd0, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_GROUP, 4'd1, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_ENTRY, 4'd1, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_ENTRY, 4'd1, 64'hFF00_0000_0000_0000, 5'd31, 16'hFFFF);
      send_req(CMD_QUERY, 4'd1, 64'hFFAB_CDEF_0123_4567, 5'd31, 16'hFFFF);
      send_req(CMD_QUERY, 4'd1, 64'h8000_0000_0000_0000, 5'd0, 16'd0);
      send_req(CMD_ADD_GROUP, 4'd8, '1, 5'd31, 16'hFFFF);
      send_req(CMD_ADD_ENTRY, 4'd8, '1, 5'd17, 16'h8001);
      send_req(CMD_QUERY, 4'd8, '1, 5'd0, 16'd0);
      send_req(CMD_QUERY, 4'd8, 64'hFFFF_FFFF_FFFF_FFFE, 5'd0, 16'd0);
      send_req(CMD_ADD_GROUP, 4'd15, '0, 5'd0, 16'd0);
      send_req(CMD_ADD_ENTRY, 4'd15, 64'h0123_4567_89AB_CDEF, 5'd9, 16'h1234);
      send_req(CMD_QUERY, 4'd15, 64'h0123_4567_89AB_CDEF, 5'd0, 16'd0);
      send_req(CMD_QUERY, 4'd5, 64'h0123_4567_89AB_CDEF, 5'd0, 16'd0);
      send_req(CMD_QUERY, 4'd15, 64'h0123_4567_89AB_CDEE, 5'd0, 16'd0);
      send_req(CMD_CLEAR, 4'd15, '1, 5'd31, 16'hFFFF);
      send_req(CMD_QUERY, 4'd1, '0, 5'd0, 16'd0);

      first_build = 1'b1;
      for (phase = 0; phase < 3; phase++) begin
         wait_for_answers();
         tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 46 : 0;
         rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 7 : 0;
         phase_end = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < phase_end) begin
            if (first_build) begin
               // every group slot used, each group filled with up to 16 entries, then one more of each
               build_table(16, 16, 1'b1, 1'b1);
               first_build = 1'b0;
            end else if ($urandom_range(14) == 0) begin
               build_table($urandom_range(9, 16), 16, 1'b1, $urandom_range(1) != 0);
            end else begin
               group_goal = $urandom_range(1, 6);
               build_table(group_goal, 6, $urandom_range(7) != 0, 1'b0);
            end
            run_queries($urandom_range(10, 40));
         end
      end

      wait_for_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
